// File: rtl/tzsp_pkg.sv
// ----------------------------------------------------------------------------
// tzsp_pkg: shared definitions for the time-zone string parser
// Widths, reset values and the snapshot record that the parser hands to the
// offset stage when a string ends.
// ----------------------------------------------------------------------------
package tzsp_pkg;

  // Default number of characters in a zone name.
  localparam int NAME_CHARS_DEF = 3;

  // Width of one parsed number (signed, magnitude up to 65535).
  localparam int NUM_W = 17;

  // Width of a name field on the result bus.
  localparam int NAME_W = 24;

  // Width of the offset field on the result bus.
  localparam int OFS_W = 32;

  // Values after reset.
  localparam logic [NAME_W-1:0] STD_NAME_RST = 24'h505354;
  localparam logic [NAME_W-1:0] DST_NAME_RST = 24'h504454;
  localparam logic [OFS_W-1:0]  OFFSET_RST   = 32'hFFFF_F1F0;

  // Everything the offset stage needs from one finished string.
  typedef struct packed {
    logic signed [NUM_W-1:0] hour;
    logic signed [NUM_W-1:0] minute;
    logic signed [NUM_W-1:0] second;
    logic                    offset_neg;
    logic                    recompute;
    logic [NAME_W-1:0]       std_name;
    logic [NAME_W-1:0]       dst_name;
  } snap_t;

endpackage

// File: rtl/tz_string_parser_unit.sv
// ----------------------------------------------------------------------------
// tz_string_parser_unit: time-zone string parser
// Reads a zone string such as "PST8PDT" one character per transfer and, when
// the string ends, delivers the signed offset in seconds and both names.
//
//   Channel   Dir  Payload                                      Ends on
//   s_axis    in   tdata[7:0] char_code, tlast is_last           -
//   m_axis    out  tdata offset/std_name/dst_name (80 bits)      one per string
//
// One character is taken in every cycle unless an ending character waits on
// a full snapshot register. A string's result passes the character register,
// which loads on the transfer, then the snapshot register and then the
// offset result register.
// Reset clears the parse state and restores the names PST/PDT and an offset
// of -3600 s. A stalled result holds the snapshot register; input is taken
// until an ending character finds that register still occupied.
// ----------------------------------------------------------------------------
module tz_string_parser_unit import tzsp_pkg::*; #(
  parameter int NAME_CHARS = NAME_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
  input  logic        s_axis_tlast,  // is_last
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // [31:0] offset_seconds, [55:32] std_name,
                                     // [79:56] dst_name
);

  logic              snap_valid;
  logic              snap_ready;
  snap_t             snap;
  logic [OFS_W-1:0]  offset;
  logic [NAME_W-1:0] std_name;
  logic [NAME_W-1:0] dst_name;

  // Character register and parse state.
  tzsp_parser #(
    .NAME_CHARS(NAME_CHARS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_valid_i(s_axis_tvalid),
    .char_ready_o(s_axis_tready),
    .char_code_i (s_axis_tdata),
    .is_last_i   (s_axis_tlast),
    .snap_valid_o(snap_valid),
    .snap_ready_i(snap_ready),
    .snap_o      (snap)
  );

  // Offset arithmetic and result register.
  tzsp_offset u_offset (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_valid_i(snap_valid),
    .snap_ready_o(snap_ready),
    .snap_i      (snap),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .offset_o    (offset),
    .std_name_o  (std_name),
    .dst_name_o  (dst_name)
  );

  assign m_axis_tdata = {dst_name, std_name, offset};

endmodule

// File: rtl/tzsp_parser.sv
// ----------------------------------------------------------------------------
// tzsp_parser: character register and parse state update
// Registers each incoming character, advances the parse state by one character
// per cycle unless an ending character waits on a full snapshot register and,
// when a string ends, loads it with the numbers, signs and names for the offset stage.
// ----------------------------------------------------------------------------
module tzsp_parser import tzsp_pkg::*; #(
  parameter int NAME_CHARS = NAME_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Character stream
  input  logic       char_valid_i,
  output logic       char_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       is_last_i,
  // Snapshot toward the offset stage
  output logic       snap_valid_o,
  input  logic       snap_ready_i,
  output snap_t      snap_o
);

  // Name store width: at least the bus field, wider for long names.
  localparam int NW = (NAME_CHARS * 8 > NAME_W) ? NAME_CHARS * 8 : NAME_W;
  localparam int PW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;

  // Parse phase codes.
  localparam logic [3:0] PH_STD    = 4'd0;
  localparam logic [3:0] PH_SIGN   = 4'd1;
  localparam logic [3:0] PH_H_LEAD = 4'd2;
  localparam logic [3:0] PH_H_DIG  = 4'd3;
  localparam logic [3:0] PH_H_SKIP = 4'd4;
  localparam logic [3:0] PH_M_LEAD = 4'd5;
  localparam logic [3:0] PH_M_DIG  = 4'd6;
  localparam logic [3:0] PH_M_SKIP = 4'd7;
  localparam logic [3:0] PH_S_LEAD = 4'd8;
  localparam logic [3:0] PH_S_DIG  = 4'd9;
  localparam logic [3:0] PH_S_SKIP = 4'd10;
  localparam logic [3:0] PH_DST    = 4'd11;
  localparam logic [3:0] PH_DONE   = 4'd12;

  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [15:0] NUM_MAX = 16'hFFFF;

  // One decimal digit into a signed number, saturating the magnitude.
  function automatic logic signed [NUM_W-1:0] accum(
    input logic signed [NUM_W-1:0] v,
    input logic                    neg,
    input logic [7:0]              c
  );
    logic [NUM_W-1:0] mag_in;
    logic [19:0]      mag;
    mag_in = neg ? NUM_W'(-v) : NUM_W'(v);
    mag    = ({4'd0, mag_in[15:0]} << 3) + ({4'd0, mag_in[15:0]} << 1)
             + {16'd0, c[3:0]};
    if (mag > {4'd0, NUM_MAX}) begin
      mag = {4'd0, NUM_MAX};
    end
    return neg ? -$signed({1'b0, mag[15:0]}) : $signed({1'b0, mag[15:0]});
  endfunction

  // Character register.
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Parse state.
  logic [3:0]              phase_q, phase_d;
  logic [PW-1:0]           pos_q, pos_d;
  logic                    off_neg_q, off_neg_d;
  logic                    num_neg_q, num_neg_d;
  logic signed [NUM_W-1:0] hour_q, hour_d;
  logic signed [NUM_W-1:0] min_q, min_d;
  logic signed [NUM_W-1:0] sec_q, sec_d;
  logic [NW-1:0]           std_q, std_d;
  logic [NW-1:0]           dst_q, dst_d;

  // Snapshot register.
  logic  snap_valid_q;
  snap_t snap_q;

  logic  in_end;
  logic  in_go;
  logic  snap_free;
  logic  recompute;

  assign snap_free    = !snap_valid_q || snap_ready_i;
  assign in_end       = (in_char_q == 8'd0) || in_last_q;
  assign in_go        = in_valid_q && (!in_end || snap_free);
  assign char_ready_o = !in_valid_q || in_go;
  assign recompute    = !((in_char_q == 8'd0) && (phase_q == PH_STD) && (pos_q == '0));

  // Next parse state for the character in the register.
  always_comb begin
    logic [7:0]    c;
    logic          digit;
    logic          ws;
    logic          sgn;
    logic [3:0]    nph;
    logic [NW-1:0] base;
    int            shamt;
    int            pos_inc;

    c       = in_char_q;
    digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    ws      = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    sgn     = (c == CH_PLUS) || (c == CH_MINUS);
    shamt   = 8 * (NAME_CHARS - 1 - int'(pos_q));
    pos_inc = int'(pos_q) + 1;
    nph     = phase_q;
    base    = std_q;

    phase_d   = phase_q;
    pos_d     = pos_q;
    off_neg_d = off_neg_q;
    num_neg_d = num_neg_q;
    hour_d    = hour_q;
    min_d     = min_q;
    sec_d     = sec_q;
    std_d     = std_q;
    dst_d     = dst_q;

    if (c != 8'd0) begin
      // The sign phase either takes the offset sign or acts as hour lead.
      if (phase_q == PH_SIGN) begin
        phase_d = PH_H_LEAD;
        if (sgn) begin
          off_neg_d = (c == CH_MINUS);
        end else begin
          nph = PH_H_LEAD;
        end
      end

      unique case (nph) inside
        PH_STD: begin
          if (pos_q == '0) begin
            base = '0;
          end
          std_d = base | (NW'(c) << shamt);
          if (pos_inc >= NAME_CHARS) begin
            phase_d = PH_SIGN;
            pos_d   = '0;
          end else begin
            pos_d = PW'(pos_inc);
          end
        end
        PH_SIGN: begin
          // Sign character already handled above.
        end
        PH_H_LEAD, PH_M_LEAD, PH_S_LEAD: begin
          if ((nph != PH_S_LEAD) && (c == CH_COLON)) begin
            phase_d   = nph + 4'd3;
            num_neg_d = 1'b0;
          end else if ((nph == PH_S_LEAD) && (c > CH_NINE)) begin
            dst_d   = NW'(c) << (8 * (NAME_CHARS - 1));
            pos_d   = PW'(1);
            phase_d = (NAME_CHARS <= 1) ? PH_DONE : PH_DST;
          end else if (ws) begin
            phase_d = nph;
          end else if (sgn) begin
            num_neg_d = (c == CH_MINUS);
            phase_d   = nph + 4'd1;
          end else if (digit) begin
            if (nph == PH_H_LEAD) begin
              hour_d = accum(hour_q, num_neg_q, c);
            end else if (nph == PH_M_LEAD) begin
              min_d = accum(min_q, num_neg_q, c);
            end else begin
              sec_d = accum(sec_q, num_neg_q, c);
            end
            phase_d = nph + 4'd1;
          end else begin
            phase_d = nph + 4'd2;
          end
        end
        PH_H_DIG, PH_M_DIG, PH_S_DIG: begin
          if ((nph != PH_S_DIG) && (c == CH_COLON)) begin
            phase_d   = nph + 4'd2;
            num_neg_d = 1'b0;
          end else if ((nph == PH_S_DIG) && (c > CH_NINE)) begin
            dst_d   = NW'(c) << (8 * (NAME_CHARS - 1));
            pos_d   = PW'(1);
            phase_d = (NAME_CHARS <= 1) ? PH_DONE : PH_DST;
          end else if (digit) begin
            if (nph == PH_H_DIG) begin
              hour_d = accum(hour_q, num_neg_q, c);
            end else if (nph == PH_M_DIG) begin
              min_d = accum(min_q, num_neg_q, c);
            end else begin
              sec_d = accum(sec_q, num_neg_q, c);
            end
          end else begin
            phase_d = nph + 4'd1;
          end
        end
        PH_H_SKIP, PH_M_SKIP: begin
          if (c == CH_COLON) begin
            phase_d   = nph + 4'd1;
            num_neg_d = 1'b0;
          end
        end
        PH_S_SKIP: begin
          if (c > CH_NINE) begin
            dst_d   = NW'(c) << (8 * (NAME_CHARS - 1));
            pos_d   = PW'(1);
            phase_d = (NAME_CHARS <= 1) ? PH_DONE : PH_DST;
          end
        end
        PH_DST: begin
          dst_d = dst_q | (NW'(c) << shamt);
          pos_d = PW'(pos_inc);
          if (pos_inc >= NAME_CHARS) begin
            phase_d = PH_DONE;
          end
        end
        default: begin
          // Done, or an unused code: the character is ignored.
        end
      endcase
    end
  end

  // Character register: loads on a transfer, empties when consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_valid_i && char_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (in_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_valid_i && char_ready_o) begin
      in_char_q <= char_code_i;
      in_last_q <= is_last_i;
    end
  end

  // Parse state: cleared after a string ends, names are kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_STD;
      pos_q     <= '0;
      off_neg_q <= 1'b0;
      num_neg_q <= 1'b0;
      hour_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      std_q     <= NW'(STD_NAME_RST);
      dst_q     <= NW'(DST_NAME_RST);
    end else if (in_go) begin
      std_q <= std_d;
      dst_q <= dst_d;
      if (in_end) begin
        phase_q   <= PH_STD;
        pos_q     <= '0;
        off_neg_q <= 1'b0;
        num_neg_q <= 1'b0;
        hour_q    <= '0;
        min_q     <= '0;
        sec_q     <= '0;
      end else begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        off_neg_q <= off_neg_d;
        num_neg_q <= num_neg_d;
        hour_q    <= hour_d;
        min_q     <= min_d;
        sec_q     <= sec_d;
      end
    end
  end

  // Snapshot register: holds one finished string until the offset stage
  // takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (in_go && in_end) begin
      snap_valid_q <= 1'b1;
    end else if (snap_ready_i) begin
      snap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go && in_end) begin
      snap_q.hour       <= hour_d;
      snap_q.minute     <= min_d;
      snap_q.second     <= sec_d;
      snap_q.offset_neg <= off_neg_d;
      snap_q.recompute  <= recompute;
      snap_q.std_name   <= std_d[NAME_W-1:0];
      snap_q.dst_name   <= dst_d[NAME_W-1:0];
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

// File: rtl/tzsp_offset.sv
// ----------------------------------------------------------------------------
// tzsp_offset: offset arithmetic and result register
// Turns a finished snapshot into the signed offset in seconds and holds the
// result until the downstream side takes it. The offset register also keeps
// the stored offset that an empty string repeats.
// ----------------------------------------------------------------------------
module tzsp_offset import tzsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Snapshot from the parser
  input  logic              snap_valid_i,
  output logic              snap_ready_o,
  input  snap_t             snap_i,
  // Result
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [OFS_W-1:0]  offset_o,
  output logic [NAME_W-1:0] std_name_o,
  output logic [NAME_W-1:0] dst_name_o
);

  localparam int TW = OFS_W + 2;

  logic              valid_q;
  logic [OFS_W-1:0]  offset_q, offset_d;
  logic [NAME_W-1:0] std_q;
  logic [NAME_W-1:0] dst_q;
  logic              load;

  assign snap_ready_o = !valid_q || res_ready_i;
  assign load         = snap_valid_i && snap_ready_o;

  // Sign times ((hour * 60 + minute) * 60 + second).
  always_comb begin
    logic signed [NUM_W-1:0] h;
    logic signed [NUM_W-1:0] m;
    logic signed [NUM_W-1:0] s;
    logic signed [TW-1:0]    hm;
    logic signed [TW-1:0]    total;

    h     = snap_i.hour;
    m     = snap_i.minute;
    s     = snap_i.second;
    hm    = TW'(h) * TW'(60) + TW'(m);
    total = hm * TW'(60) + TW'(s);
    if (snap_i.offset_neg) begin
      total = -total;
    end
    offset_d = snap_i.recompute ? total[OFS_W-1:0] : offset_q;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      offset_q <= OFFSET_RST;
    end else if (load) begin
      valid_q  <= 1'b1;
      offset_q <= offset_d;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      std_q <= snap_i.std_name;
      dst_q <= snap_i.dst_name;
    end
  end

  assign res_valid_o = valid_q;
  assign offset_o    = offset_q;
  assign std_name_o  = std_q;
  assign dst_name_o  = dst_q;

endmodule

// File: tb/sv/tzsp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tzsp_result_checker: result checker for the time-zone string parser
// Tracks every character transfer into the parser with its own copy of the
// parse state. It queues the offset and names that each ending character
// must produce, and compares every result transfer field by field with the
// oldest queued entry.
// ----------------------------------------------------------------------------
module tzsp_result_checker import tzsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [79:0] m_tdata_i,
  output int          errors_o,
  output int          pending_o
);

  // Parse phases. Each of the three numbers has a lead, a digit and a skip
  // phase, starting at PH_H_LEAD and ending at PH_S_SKIP.
  localparam logic [3:0] PH_STD    = 4'd0;
  localparam logic [3:0] PH_SIGN   = 4'd1;
  localparam logic [3:0] PH_H_LEAD = 4'd2;
  localparam logic [3:0] PH_S_SKIP = 4'd10;
  localparam logic [3:0] PH_DST    = 4'd11;
  localparam logic [3:0] PH_DONE   = 4'd12;

  // Sub-phases of one number, and the index of the seconds number.
  localparam int SUB_LEAD    = 0;
  localparam int SUB_DIGITS  = 1;
  localparam int NUM_SECONDS = 2;

  localparam int NAME_LEN     = NAME_CHARS_DEF;
  localparam int NUM_MAX      = 65535;
  localparam int SECS_PER_MIN = 60;
  localparam int MAX_PRINTS   = 40;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_COLON = ":";

  // One result, laid out as on the result bus.
  typedef struct packed {
    logic [NAME_W-1:0] dst_name;
    logic [NAME_W-1:0] std_name;
    logic [OFS_W-1:0]  offset;
  } tz_result_t;

  logic [3:0]       phase;
  int               name_pos;
  logic             offset_neg;
  logic             number_neg;
  int               num_val [3];
  logic [63:0]      std_store;
  logic [63:0]      dst_store;
  logic [OFS_W-1:0] offset_store;
  tz_result_t       expected_q [$];

  // Bit position of a name character; the first one goes to the top byte.
  function automatic int name_shift(int pos);
    return 8 * (NAME_LEN - 1 - pos);
  endfunction

  // Parse state back to its idle values; the stored names and offset stay.
  function automatic void clear_parse();
    phase      = PH_STD;
    name_pos   = 0;
    offset_neg = 1'b0;
    number_neg = 1'b0;
    foreach (num_val[i]) num_val[i] = 0;
  endfunction

  // Append one decimal digit to a number, saturating its magnitude.
  function automatic void add_digit(int slot, logic [7:0] c);
    longint mag;
    mag = number_neg ? -num_val[slot] : num_val[slot];
    mag = mag * 10 + (c - CH_ZERO);
    if (mag > NUM_MAX) mag = NUM_MAX;
    num_val[slot] = number_neg ? -int'(mag) : int'(mag);
  endfunction

  // One character while reading hours, minutes or seconds.
  function automatic void number_step(logic [7:0] c);
    int   k;
    int   sub;
    logic is_digit;
    logic is_space;
    k        = (int'(phase) - int'(PH_H_LEAD)) / 3;
    sub      = (int'(phase) - int'(PH_H_LEAD)) % 3;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    if (k == NUM_SECONDS && c > CH_NINE) begin
      // The daylight name starts right after the seconds text.
      dst_store = {56'd0, c} << name_shift(0);
      name_pos  = 1;
      phase     = (name_pos >= NAME_LEN) ? PH_DONE : PH_DST;
    end else if (k < NUM_SECONDS && c == CH_COLON) begin
      phase      = PH_H_LEAD + 4'(3 * (k + 1));
      number_neg = 1'b0;
    end else if (sub == SUB_LEAD) begin
      if (!is_space) begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          number_neg = (c == CH_MINUS);
          phase      = phase + 4'd1;
        end else if (is_digit) begin
          add_digit(k, c);
          phase = phase + 4'd1;
        end else begin
          phase = phase + 4'd2;
        end
      end
    end else if (sub == SUB_DIGITS) begin
      if (is_digit) add_digit(k, c);
      else phase = phase + 4'd1;
    end
  endfunction

  // One non-NUL character of the zone text.
  function automatic void take_char(logic [7:0] c);
    case (phase)
      PH_STD: begin
        if (name_pos == 0) std_store = '0;
        std_store = std_store | ({56'd0, c} << name_shift(name_pos));
        name_pos++;
        if (name_pos >= NAME_LEN) begin
          phase    = PH_SIGN;
          name_pos = 0;
        end
      end
      PH_SIGN: begin
        phase = PH_H_LEAD;
        if (c == CH_PLUS || c == CH_MINUS) offset_neg = (c == CH_MINUS);
        else number_step(c);
      end
      PH_DST: begin
        dst_store = dst_store | ({56'd0, c} << name_shift(name_pos));
        name_pos++;
        if (name_pos >= NAME_LEN) phase = PH_DONE;
      end
      default: begin
        if (phase >= PH_H_LEAD && phase <= PH_S_SKIP) number_step(c);
      end
    endcase
  endfunction

  // Print one failure line (up to a limit) and count it.
  task automatic report_error(string msg);
    if (errors_o < MAX_PRINTS) $display("%0t ns: ERROR %s", $time, msg);
    errors_o++;
  endtask

  // Follow both channels; characters are modeled before results are checked.
  always @(posedge clk_i or negedge rst_ni) begin : follow_transfers
    tz_result_t got;
    tz_result_t want;
    longint     total;
    if (!rst_ni) begin
      clear_parse();
      std_store    = {40'd0, STD_NAME_RST};
      dst_store    = {40'd0, DST_NAME_RST};
      offset_store = OFFSET_RST;
      expected_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        if (s_tdata_i != CH_NUL) take_char(s_tdata_i);
        if (s_tdata_i == CH_NUL || s_tlast_i) begin
          // An empty string repeats the stored result unchanged.
          if (!(s_tdata_i == CH_NUL && phase == PH_STD && name_pos == 0)) begin
            total = (longint'(num_val[0]) * SECS_PER_MIN + num_val[1]) * SECS_PER_MIN
                    + num_val[2];
            if (offset_neg) total = -total;
            offset_store = total[OFS_W-1:0];
          end
          want.offset   = offset_store;
          want.std_name = std_store[NAME_W-1:0];
          want.dst_name = dst_store[NAME_W-1:0];
          expected_q.push_back(want);
          clear_parse();
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (expected_q.size() == 0) begin
          report_error($sformatf("result %h with no string pending", m_tdata_i));
        end else begin
          want = expected_q.pop_front();
          if (got.offset !== want.offset)
            report_error($sformatf("offset_seconds %0d, expected %0d",
                                   $signed(got.offset), $signed(want.offset)));
          if (got.std_name !== want.std_name)
            report_error($sformatf("std_name %h, expected %h", got.std_name, want.std_name));
          if (got.dst_name !== want.dst_name)
            report_error($sformatf("dst_name %h, expected %h", got.dst_name, want.dst_name));
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the time-zone string parser
// Sends a few hand-made zone strings, then random ones: mostly well-formed
// texts with names, signs and up to three numbers, and some cut short or
// pure noise. Strings end on a NUL, on the last flag or on both. Both sides
// idle and stall in several phases; a separate checker compares the results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int IDLE_PHASES     = 4;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 20;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_COLON = ":";

  // How a string is terminated.
  typedef enum int {END_NUL, END_LAST, END_NUL_LAST} text_end_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  int         sender_idle_pct    = 0;
  int         receiver_stall_pct = 0;
  int         chars_sent         = 0;
  int         quiet_cycles       = 0;
  int         errors;
  int         pending;
  logic [7:0] text_q [$];

  tz_string_parser_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tzsp_result_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // Clock.
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Result side stalls at random with the current percentage.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // End the run when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tz_string_parser_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one character, with random idle cycles before it, and wait for the
  // transfer. Starts and ends at a falling edge.
  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chars_sent++;
    @(negedge clk_i);
  endtask

  // Send the queued text and terminate it.
  task automatic send_text(text_end_e how);
    if (text_q.size() == 0 && how == END_LAST) how = END_NUL;
    foreach (text_q[i])
      send_char(text_q[i], how == END_LAST && i == text_q.size() - 1);
    if (how != END_LAST) send_char(CH_NUL, how == END_NUL_LAST);
  endtask

  function automatic void load_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(1, 255));
  endfunction

  // Upper-case ASCII letter.
  function automatic logic [7:0] letter();
    return 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  // One number: optional white space and sign, digits (a few long enough to
  // saturate), and now and then a stray character after it.
  function automatic void push_number();
    int digits;
    if ($urandom_range(3) == 0)
      text_q.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom_range(9, 13)));
    if ($urandom_range(3) == 0) text_q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
    digits = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 2);
    repeat (digits) text_q.push_back(8'($urandom_range(8'h30, 8'h39)));
    if ($urandom_range(7) == 0) text_q.push_back(any_char());
  endfunction

  // Random zone text: mostly well-formed, some cut short, some noise.
  function automatic void build_text();
    int kind;
    int cut;
    int sign_pick;
    text_q.delete();
    kind = $urandom_range(99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 12)) text_q.push_back(any_char());
    end else begin
      repeat (3) text_q.push_back($urandom_range(4) == 0 ? any_char() : letter());
      sign_pick = $urandom_range(2);
      if (sign_pick < 2) text_q.push_back(sign_pick == 0 ? CH_PLUS : CH_MINUS);
      push_number();
      if ($urandom_range(99) < 85) begin
        text_q.push_back(CH_COLON);
        push_number();
        if ($urandom_range(99) < 80) begin
          text_q.push_back(CH_COLON);
          push_number();
        end
      end
      // Filler up to '9', then the daylight name and maybe trailing text.
      repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(1, 8'h39)));
      if ($urandom_range(9) < 8) begin
        text_q.push_back(8'($urandom_range(8'h3A, 255)));
        repeat (2) text_q.push_back($urandom_range(3) == 0 ? any_char() : letter());
        repeat ($urandom_range(0, 2)) text_q.push_back(any_char());
      end
      if (kind < 30) begin
        cut = $urandom_range(0, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
    end
  endfunction

  initial begin
    int        pick;
    text_end_e how;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty string straight after reset repeats the reset result.
    text_q.delete();
    send_text(END_NUL);
    // Full text with an hour suffix that is ignored and trailing text.
    load_text("EST+5h:30:00EDTx");
    send_text(END_LAST);
    // Text shorter than a name, highest character codes.
    text_q.delete();
    text_q.push_back(8'hFF);
    text_q.push_back(8'h80);
    send_text(END_LAST);
    // Saturating hour, negative offset, no daylight name given.
    text_q.delete();
    text_q.push_back(8'h01);
    text_q.push_back(8'h7F);
    load_text("Q- 99999");
    send_text(END_NUL_LAST);

    // Random strings under each idling pattern.
    for (int p = 0; p < IDLE_PHASES; p++) begin
      case (p)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 49;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 49;
        end
        default: begin
          sender_idle_pct    = 20;
          receiver_stall_pct = 20;
        end
      endcase
      while (chars_sent < (p + 1) * ITEMS_PER_PHASE) begin
        build_text();
        pick = $urandom_range(99);
        how  = (pick < 40) ? END_NUL : (pick < 85) ? END_LAST : END_NUL_LAST;
        send_text(how);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tz_string_parser_unit test passed");
    end else begin
      $display("tz_string_parser_unit test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tzsp_pkg.sv
rtl/tzsp_parser.sv
rtl/tzsp_offset.sv
rtl/tz_string_parser_unit.sv
tb/sv/tzsp_result_checker.sv
tb/sv/testbench.sv
